/* src/blrp_pkg.sv */
package blrp_pkg;

  typedef struct packed {
    logic       cmd;
    logic [8:0] rect_width;
    logic [8:0] rect_height;
  } blrp_in_t;

  typedef struct packed {
    logic       placed;
    logic [5:0] x_start;
    logic [7:0] y_start;
    logic [5:0] x_end;
    logic [7:0] y_end;
    logic [8:0] used_length;
  } blrp_out_t;

  localparam logic       CMD_NEW_JOB    = 1'b1;
  localparam logic [6:0] ROLL_WIDTH_RST = 7'd64;

endpackage

/* src/blrp_ram.sv */
module blrp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/bottom_left_rect_placer_core.sv */
// Bottom-left strip packer. Each place transfer scans candidate rows from the
// bottom: for row y it reads rows y.. of the occupancy memory one per cycle
// (up to the longer side), then tries columns left to right one per cycle (up
// to the strip width), trying the longer side along the width first, then
// rotated. A hit is marked with a read-modify-write (S_MRD, then S_MWR) of each
// covered row; a new-job transfer clears the sheet. A rectangle that fits
// nowhere, or has a zero side, returns placed = 0.
module bottom_left_rect_placer_core #(
  parameter int GRID_COLUMNS = 64,
  parameter int GRID_ROWS    = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  blrp_pkg::blrp_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output blrp_pkg::blrp_out_t out_data_o
);
  import blrp_pkg::*;

  localparam int XW   = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int RW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int YW   = $clog2(GRID_ROWS + 1);
  localparam int SUMW = YW + 11;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_MRD  = 3'd4;
  localparam logic [2:0] S_MWR  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  function automatic logic [GRID_COLUMNS-1:0] low_mask(input logic [8:0] n);
    logic [GRID_COLUMNS-1:0] m;
    m = '1;
    if (32'(n) < GRID_COLUMNS) m = ~({GRID_COLUMNS{1'b1}} << n);
    return m;
  endfunction

  logic [2:0]              state_q, state_d;
  logic [6:0]              roll_q, roll_d;
  logic [8:0]              w_q, w_d, h_q, h_d, pw_q, pw_d, ph_q, ph_d;
  logic [8:0]              k_q, k_d;
  logic [YW-1:0]           y_q, y_d, len_q, len_d;
  logic [XW-1:0]           x_q, x_d, px_q, px_d;
  logic [RW-1:0]           py_q, py_d, rd_row_q, rd_row_d;
  logic [GRID_COLUMNS-1:0] acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic [GRID_ROWS-1:0]    vld_q, vld_d;
  logic                    ok_q, ok_d, out_vld_q, out_vld_d;
  blrp_out_t               res_q, res_d;

  logic                    ram_we;
  logic [RW-1:0]           ram_waddr, ram_raddr;
  logic [GRID_COLUMNS-1:0] ram_wdata, ram_rdata, row_data;
  logic [SUMW-1:0]         strip, row_k, y_ext;
  logic                    fit_a, fit_b;
  logic [8:0]              side_l, side_s;

  blrp_ram #(.WIDTH(GRID_COLUMNS), .DEPTH(GRID_ROWS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  always_comb begin
    strip = (32'(roll_q) > GRID_COLUMNS) ? SUMW'(GRID_COLUMNS) : SUMW'(roll_q);
    y_ext = SUMW'(y_q);
    row_k = y_ext + SUMW'(k_q);
    row_data = vld_q[rd_row_q] ? ram_rdata : '0;
    side_l = (in_data_i.rect_width > in_data_i.rect_height) ?
             in_data_i.rect_width : in_data_i.rect_height;
    side_s = (in_data_i.rect_width > in_data_i.rect_height) ?
             in_data_i.rect_height : in_data_i.rect_width;
    fit_a = (y_ext + SUMW'(h_q) <= SUMW'(GRID_ROWS)) &&
            (SUMW'(x_q) + SUMW'(w_q) <= strip) &&
            (((acc_a_q >> x_q) & low_mask(w_q)) == '0);
    fit_b = (w_q != h_q) &&
            (y_ext + SUMW'(w_q) <= SUMW'(GRID_ROWS)) &&
            (SUMW'(x_q) + SUMW'(h_q) <= strip) &&
            (((acc_b_q >> x_q) & low_mask(h_q)) == '0);
  end

  always_comb begin
    state_d   = state_q;
    roll_d    = roll_q;
    w_d       = w_q;
    h_d       = h_q;
    pw_d      = pw_q;
    ph_d      = ph_q;
    k_d       = k_q;
    y_d       = y_q;
    len_d     = len_q;
    x_d       = x_q;
    px_d      = px_q;
    py_d      = py_q;
    rd_row_d  = rd_row_q;
    acc_a_d   = acc_a_q;
    acc_b_d   = acc_b_q;
    vld_d     = vld_q;
    ok_d      = ok_q;
    out_vld_d = out_vld_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = py_q + RW'(k_q);
    ram_wdata = row_data | (low_mask(pw_q) << px_q);
    ram_raddr = RW'(row_k);

    if (cfg_we_i) roll_d = cfg_wdata_i;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ok_d = 1'b0;
          w_d  = side_l;
          h_d  = side_s;
          y_d  = '0;
          k_d  = '0;
          if (in_data_i.cmd == CMD_NEW_JOB) begin
            vld_d   = '0;
            len_d   = '0;
            state_d = S_FIN;
          end else if (side_s == 9'd0 || 32'(side_s) > GRID_ROWS) begin
            state_d = S_FIN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        // start gathering rows y.. into the two column masks
        acc_a_d  = '0;
        acc_b_d  = '0;
        ram_raddr = RW'(y_ext);
        rd_row_d = RW'(y_ext);
        k_d      = 9'd1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        if (k_q - 9'd1 < h_q) acc_a_d = acc_a_q | row_data;
        acc_b_d = acc_b_q | row_data;
        if (k_q < w_q && row_k < SUMW'(GRID_ROWS)) begin
          rd_row_d = RW'(row_k);
          k_d      = k_q + 9'd1;
        end else begin
          x_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fit_a || fit_b) begin
          px_d    = x_q;
          py_d    = RW'(y_q);
          pw_d    = fit_a ? w_q : h_q;
          ph_d    = fit_a ? h_q : w_q;
          k_d     = '0;
          state_d = S_MRD;
        end else if (SUMW'(x_q) + SUMW'(1) < strip) begin
          x_d = x_q + XW'(1);
        end else if (y_ext + SUMW'(1) + SUMW'(h_q) > SUMW'(GRID_ROWS)) begin
          state_d = S_FIN;
        end else begin
          y_d     = y_q + YW'(1);
          state_d = S_READ;
        end
      end
      S_MRD: begin
        ram_raddr = py_q + RW'(k_q);
        rd_row_d  = py_q + RW'(k_q);
        state_d   = S_MWR;
      end
      S_MWR: begin
        ram_we          = 1'b1;
        vld_d[rd_row_q] = 1'b1;
        if (k_q + 9'd1 < ph_q) begin
          k_d     = k_q + 9'd1;
          state_d = S_MRD;
        end else begin
          ok_d = 1'b1;
          if (SUMW'(py_q) + SUMW'(ph_q) > SUMW'(len_q)) len_d = YW'(SUMW'(py_q) + SUMW'(ph_q));
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_vld_q || out_ready_i) begin
          res_d.placed      = ok_q;
          res_d.x_start     = ok_q ? 6'(px_q) : 6'd0;
          res_d.y_start     = ok_q ? 8'(py_q) : 8'd0;
          res_d.x_end       = ok_q ? 6'(SUMW'(px_q) + SUMW'(pw_q) - SUMW'(1)) : 6'd0;
          res_d.y_end       = ok_q ? 8'(SUMW'(py_q) + SUMW'(ph_q) - SUMW'(1)) : 8'd0;
          res_d.used_length = 9'(len_q);
          out_vld_d         = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      roll_q    <= ROLL_WIDTH_RST;
      len_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      roll_q    <= roll_d;
      len_q     <= len_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    h_q      <= h_d;
    pw_q     <= pw_d;
    ph_q     <= ph_d;
    k_q      <= k_d;
    y_q      <= y_d;
    x_q      <= x_d;
    px_q     <= px_d;
    py_q     <= py_d;
    rd_row_q <= rd_row_d;
    acc_a_q  <= acc_a_d;
    acc_b_q  <= acc_b_d;
    ok_q     <= ok_d;
    res_q    <= res_d;
  end

endmodule

/* verif/blrp_checker.sv */
module blrp_checker #(
  parameter int GRID_COLUMNS = 64,
  parameter int GRID_ROWS    = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  blrp_pkg::blrp_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  blrp_pkg::blrp_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import blrp_pkg::*;

  logic [GRID_COLUMNS-1:0] sheet [GRID_ROWS];
  int unsigned             strip_cols;
  int unsigned             length_used;
  blrp_out_t               expected_q [$];

  function automatic bit region_free(int unsigned x, int unsigned y, int unsigned w,
                                     int unsigned h);
    logic [GRID_COLUMNS-1:0] mask;
    if (x + w > strip_cols || y + h > GRID_ROWS) return 0;
    mask = ((GRID_COLUMNS'(1) << w) - 1) << x;
    for (int unsigned j = y; j < y + h; j++)
      if ((sheet[j] & mask) != '0) return 0;
    return 1;
  endfunction

  function automatic blrp_out_t place_rect(blrp_in_t item);
    blrp_out_t res;
    int unsigned lw, sh, pw, ph, px, py;
    logic [GRID_COLUMNS-1:0] mask;
    bit hit;
    res = '0;
    hit = 0;
    pw = 0; ph = 0; px = 0; py = 0;
    lw = (item.rect_width > item.rect_height) ? item.rect_width : item.rect_height;
    sh = (item.rect_width > item.rect_height) ? item.rect_height : item.rect_width;
    if (item.cmd == CMD_NEW_JOB) begin
      foreach (sheet[r]) sheet[r] = '0;
      length_used = 0;
    end else if (sh != 0) begin
      for (int unsigned y = 0; y < GRID_ROWS && !hit; y++) begin
        for (int unsigned x = 0; x < strip_cols && !hit; x++) begin
          if (region_free(x, y, lw, sh)) begin
            pw = lw; ph = sh; hit = 1;
          end else if (lw != sh && region_free(x, y, sh, lw)) begin
            pw = sh; ph = lw; hit = 1;
          end
          if (hit) begin
            px = x; py = y;
          end
        end
      end
      if (hit) begin
        mask = ((GRID_COLUMNS'(1) << pw) - 1) << px;
        for (int unsigned j = py; j < py + ph; j++) sheet[j] |= mask;
        if (py + ph > length_used) length_used = py + ph;
      end
    end
    if (hit) begin
      res.placed  = 1'b1;
      res.x_start = 6'(px);
      res.y_start = 8'(py);
      res.x_end   = 6'(px + pw - 1);
      res.y_end   = 8'(py + ph - 1);
    end
    res.used_length = 9'(length_used);
    return res;
  endfunction

  task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blrp_out_t exp_r;
    if (!rst_ni) begin
      foreach (sheet[r]) sheet[r] = '0;
      strip_cols   = ROLL_WIDTH_RST;
      length_used  = 0;
      fail_count_o = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_data_i);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          report_field("placed", exp_r.placed, out_data_i.placed);
          report_field("x_start", exp_r.x_start, out_data_i.x_start);
          report_field("y_start", exp_r.y_start, out_data_i.y_start);
          report_field("x_end", exp_r.x_end, out_data_i.x_end);
          report_field("y_end", exp_r.y_end, out_data_i.y_end);
          report_field("used_length", exp_r.used_length, out_data_i.used_length);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(), place_rect(in_data_i));
      // width above the grid saturates
      if (cfg_we_i)
        strip_cols = (cfg_wdata_i > GRID_COLUMNS) ? GRID_COLUMNS : cfg_wdata_i;
      pending_o = expected_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import blrp_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  blrp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  blrp_out_t out_data;
  int        fail_count;
  int        pending;
  bit        hold_off_req = 0;

  bottom_left_rect_placer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  blrp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  // Ready only moves at rising edges, so its value at the falling edge decides the transfer.
  task automatic send_rect(logic cmd, logic [8:0] w, logic [8:0] h, bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = '{cmd: cmd, rect_width: w, rect_height: h};
    while (!in_ready) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(logic [6:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic random_rect();
    logic [8:0] w, h;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      send_rect(CMD_NEW_JOB, 9'($urandom), 9'($urandom), 1);
    end else if (sel < 9) begin
      // rare oversized or zero side: long scans, keep them few
      w = 9'($urandom);
      h = ($urandom_range(0, 1) != 0) ? 9'd0 : 9'($urandom_range(1, 4));
      send_rect(~CMD_NEW_JOB, w, h, 1);
    end else begin
      w = (sel < 25) ? 9'($urandom_range(1, 40)) : 9'($urandom_range(1, 8));
      h = 9'($urandom_range(1, 8));
      if ($urandom_range(0, 1) != 0) send_rect(~CMD_NEW_JOB, w, h, 1);
      else send_rect(~CMD_NEW_JOB, h, w, 1);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off_req = 0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 9) < 2) begin
        out_ready = 1'b0;
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [6:0] widths [6];
    widths = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd40, 7'd17};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset width of 64
    send_rect(~CMD_NEW_JOB, 9'd1, 9'd1, 0);
    send_rect(~CMD_NEW_JOB, 9'd63, 9'd1, 0);
    send_rect(~CMD_NEW_JOB, 9'd1, 9'd64, 0);
    send_rect(~CMD_NEW_JOB, 9'd2, 9'd2, 1);
    send_rect(~CMD_NEW_JOB, 9'd65, 9'd1, 1);
    send_rect(~CMD_NEW_JOB, 9'd0, 9'd5, 1);
    send_rect(~CMD_NEW_JOB, 9'd7, 9'd0, 1);
    send_rect(~CMD_NEW_JOB, 9'd511, 9'd511, 1);
    send_rect(CMD_NEW_JOB, 9'd511, 9'd511, 1);
    send_rect(~CMD_NEW_JOB, 9'd256, 9'd1, 0);
    send_rect(~CMD_NEW_JOB, 9'd256, 9'd63, 0);
    send_rect(~CMD_NEW_JOB, 9'd1, 9'd1, 0);
    send_rect(~CMD_NEW_JOB, 9'd64, 9'd256, 0);
    send_rect(CMD_NEW_JOB, 9'd0, 9'd0, 0);
    send_rect(~CMD_NEW_JOB, 9'd64, 9'd64, 0);
    send_rect(~CMD_NEW_JOB, 9'd3, 9'd5, 0);

    hold_off_req = 1;
    for (int k = 0; k < 12; k++) send_rect(~CMD_NEW_JOB, 9'd1, 9'd2, 0);

    foreach (widths[p]) begin
      drain_and_write(widths[p]);
      send_rect(CMD_NEW_JOB, 9'd0, 9'd0, 0);
      if (widths[p] == 7'd1) send_rect(~CMD_NEW_JOB, 9'd1, 9'd3, 1);
      if (widths[p] == 7'd0) begin
        send_rect(~CMD_NEW_JOB, 9'd1, 9'd1, 1);
        continue;
      end
      repeat (20) random_rect();
    end
    drain_and_write(7'($urandom_range(1, 64)));
    repeat (10) random_rect();

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/blrp_pkg.sv
src/blrp_ram.sv
src/bottom_left_rect_placer_core.sv
verif/blrp_checker.sv
verif/testbench.sv
